// ===== hdl/bft_pkg.sv =====
// Shared types and constants of the bidirectional flow table.
// Used by the hash unit, the table core, the top level and the checker.
package bft_pkg;

  // The bucket count is a power of two, so the bucket is the low hash bits.
  localparam int unsigned BUCKETS = 1024;
  localparam int unsigned WAYS    = 4;
  localparam int unsigned BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(BUCKETS - 1);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  typedef enum logic {
    OP_TRACK  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_CREATED = 3'd1,
    ST_IGNORED = 3'd2,
    ST_FULL    = 3'd3,
    ST_HIT     = 3'd4,
    ST_MISS    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HASH,
    CS_READ,
    CS_EVAL
  } core_state_e;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } tuple_t;

  typedef struct packed {
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic [7:0]  proto;
    logic [31:0] ident;
    logic [31:0] start;
    logic [31:0] pkts_ab;
    logic [31:0] pkts_ba;
    logic [63:0] bytes_ab;
    logic [63:0] bytes_ba;
  } entry_t;

  typedef struct packed {
    logic [WAYS-1:0]       valid;
    entry_t [WAYS-1:0]     ent;
  } row_t;

endpackage

// ===== hdl/bidirectional_flow_table.sv =====
// Top level of the bidirectional five-tuple flow table.
// Instantiates bft_hash and bft_core; depends on bft_pkg.
//
//   Channel  Handshake                   Payload
//   in       in_valid_i / in_ready_o     operation .. timestamp
//   out      out_valid_o / out_ready_i   status .. first_seen
//
// An item goes from input transfer to result through the hash (five FNV multiplies, then the
// bucket handoff), a bucket read, and a compare and write-back step. The next item is
// taken the cycle after write-back. After reset a clearing pass writes every bucket row
// with in_ready_o low. A stalled result holds the block in its write-back step.
module bidirectional_flow_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] sport_i,
  input  logic [15:0] dport_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] length_i,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] conv_id_o,
  output logic        dir_fwd_o,
  output logic [31:0] packets_fwd_o,
  output logic [31:0] packets_rev_o,
  output logic [63:0] byte_cnt_fwd_o,
  output logic [63:0] byte_cnt_rev_o,
  output logic [31:0] first_seen_o
);
  import bft_pkg::*;

  tuple_t           tuple;
  logic             hash_start;
  logic             hash_done;
  logic [BKT_W-1:0] hash_bucket;

  always_comb begin
    tuple.src_ip   = src_ip_i;
    tuple.dst_ip   = dst_ip_i;
    tuple.sport    = sport_i;
    tuple.dport    = dport_i;
    tuple.protocol = protocol_i;
  end

  bft_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .tuple_i  (tuple),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  bft_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .tuple_i        (tuple),
    .length_i       (length_i),
    .timestamp_i    (timestamp_i),
    .hash_start_o   (hash_start),
    .hash_done_i    (hash_done),
    .hash_bucket_i  (hash_bucket),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .conv_id_o      (conv_id_o),
    .dir_fwd_o      (dir_fwd_o),
    .packets_fwd_o  (packets_fwd_o),
    .packets_rev_o  (packets_rev_o),
    .byte_cnt_fwd_o (byte_cnt_fwd_o),
    .byte_cnt_rev_o (byte_cnt_rev_o),
    .first_seen_o   (first_seen_o)
  );

endmodule

// ===== hdl/bft_hash.sv =====
// Bucket hash: FNV-1a, applied word by word, over the order-normalized five-tuple, one multiply a
// cycle; the bucket is the low bits of the final hash.
// Depends on bft_pkg.
module bft_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  bft_pkg::tuple_t       tuple_i,
  output logic                  done_o,
  output logic [bft_pkg::BKT_W-1:0] bucket_o
);
  import bft_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [2:0]        step_q, step_d;
  logic [31:0]       h_q, h_d;
  logic [31:0]       lo_a_q, hi_a_q;
  logic [15:0]       lo_p_q, hi_p_q;
  logic [7:0]        pr_q;
  logic [31:0]       word;
  logic [63:0]       prod;

  always_comb begin
    case (step_q)
      3'd0:    word = lo_a_q;
      3'd1:    word = hi_a_q;
      3'd2:    word = {16'd0, lo_p_q};
      3'd3:    word = {16'd0, hi_p_q};
      default: word = {24'd0, pr_q};
    endcase
  end

  assign prod = {32'd0, h_q ^ word} * {32'd0, FNV_PRIME};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    h_d    = h_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      h_d    = FNV_BASIS;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      h_d    = prod[31:0];
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (start_i) begin
      lo_a_q <= (tuple_i.src_ip < tuple_i.dst_ip) ? tuple_i.src_ip : tuple_i.dst_ip;
      hi_a_q <= (tuple_i.src_ip < tuple_i.dst_ip) ? tuple_i.dst_ip : tuple_i.src_ip;
      lo_p_q <= (tuple_i.sport < tuple_i.dport) ? tuple_i.sport : tuple_i.dport;
      hi_p_q <= (tuple_i.sport < tuple_i.dport) ? tuple_i.dport : tuple_i.sport;
      pr_q   <= tuple_i.protocol;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = h_q[BKT_W-1:0];

endmodule

// ===== hdl/bft_core.sv =====
// Table core: bucket memory, sequencer, way compare, counter update and
// result register. Depends on bft_pkg.
module bft_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  bft_pkg::tuple_t           tuple_i,
  input  logic [15:0]               length_i,
  input  logic [31:0]               timestamp_i,
  output logic                      hash_start_o,
  input  logic                      hash_done_i,
  input  logic [bft_pkg::BKT_W-1:0] hash_bucket_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic [31:0]               conv_id_o,
  output logic                      dir_fwd_o,
  output logic [31:0]               packets_fwd_o,
  output logic [31:0]               packets_rev_o,
  output logic [63:0]               byte_cnt_fwd_o,
  output logic [63:0]               byte_cnt_rev_o,
  output logic [31:0]               first_seen_o
);
  import bft_pkg::*;

  row_t mem [BUCKETS];

  core_state_e      state_q, state_d;
  logic [BKT_W-1:0] clr_q, clr_d;
  logic [31:0]      next_id_q, next_id_d;
  logic             op_q;
  tuple_t           tup_q;
  logic [15:0]      len_q;
  logic [31:0]      ts_q;
  logic [BKT_W-1:0] bucket_q;
  row_t             rd_q;

  logic             mem_we;
  logic [BKT_W-1:0] mem_waddr;
  row_t             mem_wdata;
  logic             mem_re;
  logic             accept;
  logic             can_fin;
  logic             finish;

  logic [WAYS-1:0]  match;
  logic             hit, free;
  logic [WAY_W-1:0] hit_way, free_way, sel_way;
  logic             ignored, fwd, write_row, create;
  entry_t           cur, upd;
  row_t             new_row;
  status_e          res_status;
  entry_t           res_ent;
  logic             res_fwd;

  logic             out_valid_q;
  status_e          status_q;
  entry_t           res_q;
  logic             fwd_q;

  assign accept  = (state_q == CS_IDLE) && in_valid_i;
  assign can_fin = !out_valid_q || out_ready_i;
  assign finish  = (state_q == CS_EVAL) && can_fin;

  // Way compare and selection on the row read back from memory.
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = rd_q.valid[w] && (rd_q.ent[w].proto == tup_q.protocol) &&
                 (((rd_q.ent[w].addr_a == tup_q.src_ip) &&
                   (rd_q.ent[w].addr_b == tup_q.dst_ip) &&
                   (rd_q.ent[w].port_a == tup_q.sport) &&
                   (rd_q.ent[w].port_b == tup_q.dport)) ||
                  ((rd_q.ent[w].addr_a == tup_q.dst_ip) &&
                   (rd_q.ent[w].addr_b == tup_q.src_ip) &&
                   (rd_q.ent[w].port_a == tup_q.dport) &&
                   (rd_q.ent[w].port_b == tup_q.sport)));
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_q.valid[w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    ignored = (op_q == OP_TRACK) && (tup_q.protocol != PROTO_TCP) &&
              (tup_q.protocol != PROTO_UDP);
    sel_way = hit ? hit_way : free_way;
    cur     = rd_q.ent[sel_way];
    if (!hit) begin
      cur          = '0;
      cur.addr_a   = tup_q.src_ip;
      cur.addr_b   = tup_q.dst_ip;
      cur.port_a   = tup_q.sport;
      cur.port_b   = tup_q.dport;
      cur.proto    = tup_q.protocol;
      cur.ident    = next_id_q;
      cur.start    = ts_q;
    end
    fwd = (cur.addr_a == tup_q.src_ip) && (cur.port_a == tup_q.sport);
    upd = cur;
    if (fwd) begin
      upd.pkts_ab  = cur.pkts_ab + 32'd1;
      upd.bytes_ab = cur.bytes_ab + {48'd0, len_q};
    end else begin
      upd.pkts_ba  = cur.pkts_ba + 32'd1;
      upd.bytes_ba = cur.bytes_ba + {48'd0, len_q};
    end
    write_row = (op_q == OP_TRACK) && !ignored && (hit || free);
    create    = write_row && !hit;
    new_row   = rd_q;
    new_row.valid[sel_way] = 1'b1;
    new_row.ent[sel_way]   = upd;

    res_ent = '0;
    res_fwd = 1'b0;
    if (ignored) begin
      res_status = ST_IGNORED;
    end else if (op_q == OP_LOOKUP) begin
      if (hit) begin
        res_status = ST_HIT;
        res_ent    = cur;
        res_fwd    = fwd;
      end else begin
        res_status = ST_MISS;
      end
    end else if (hit) begin
      res_status = ST_UPDATED;
      res_ent    = upd;
      res_fwd    = fwd;
    end else if (free) begin
      res_status = ST_CREATED;
      res_ent    = upd;
      res_fwd    = fwd;
    end else begin
      res_status = ST_FULL;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_CLEAR: if (clr_q == LAST_BUCKET) state_d = CS_IDLE;
      CS_IDLE:  if (in_valid_i) state_d = CS_HASH;
      CS_HASH:  if (hash_done_i) state_d = CS_READ;
      CS_READ:  state_d = CS_EVAL;
      CS_EVAL:  if (can_fin) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    hash_start_o = 1'b0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = bucket_q;
    mem_wdata    = new_row;
    clr_d        = clr_q;
    next_id_d    = next_id_q;
    case (state_q)
      CS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      CS_IDLE: begin
        in_ready_o   = 1'b1;
        hash_start_o = in_valid_i;
      end
      CS_READ: mem_re = 1'b1;
      CS_EVAL: begin
        mem_we = can_fin && write_row;
        if (can_fin && create) begin
          next_id_d = next_id_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[bucket_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_CLEAR;
      clr_q       <= '0;
      next_id_q   <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      next_id_q <= next_id_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      tup_q <= tuple_i;
      len_q <= length_i;
      ts_q  <= timestamp_i;
    end
    if ((state_q == CS_HASH) && hash_done_i) begin
      bucket_q <= hash_bucket_i;
    end
    if (finish) begin
      status_q <= res_status;
      res_q    <= res_ent;
      fwd_q    <= res_fwd;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign conv_id_o      = res_q.ident;
  assign dir_fwd_o      = fwd_q;
  assign packets_fwd_o  = res_q.pkts_ab;
  assign packets_rev_o  = res_q.pkts_ba;
  assign byte_cnt_fwd_o = res_q.bytes_ab;
  assign byte_cnt_rev_o = res_q.bytes_ba;
  assign first_seen_o   = res_q.start;

endmodule

// ===== hdl/bft_checker.sv =====
// Port-level checks of the flow table, attached to the top level by bind.
// Depends on bft_pkg and bidirectional_flow_table.
module bft_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] conv_id_o,
  input logic        dir_fwd_o,
  input logic [31:0] packets_fwd_o,
  input logic [31:0] packets_rev_o,
  input logic [63:0] byte_cnt_fwd_o
);
  import bft_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(conv_id_o))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISS || status_o == ST_FULL ||
                    status_o == ST_IGNORED) |-> conv_id_o == 32'd0 &&
    packets_fwd_o == 32'd0 && packets_rev_o == 32'd0 && byte_cnt_fwd_o == 64'd0)
    else $error("empty result carries data");

  a_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CREATED |->
    dir_fwd_o && packets_fwd_o == 32'd1 && packets_rev_o == 32'd0)
    else $error("new conversation counters wrong");

  a_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input taken during clearing pass");

endmodule

bind bidirectional_flow_table bft_checker u_bft_checker (.*);

// ===== bench/tb_bidirectional_flow_table.sv =====
// Testbench for the bidirectional five-tuple flow table: directed and random packets,
// predicted by an in-bench model of the hashed set-associative table and checked per field.
// Depends on bft_pkg and the bidirectional_flow_table RTL.
module tb_bidirectional_flow_table;
  import bft_pkg::*;

  localparam int NUM_RANDOM = 500;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] conv_id;
    logic        dir_fwd;
    logic [31:0] packets_fwd;
    logic [31:0] packets_rev;
    logic [63:0] byte_cnt_fwd;
    logic [63:0] byte_cnt_rev;
    logic [31:0] first_seen;
  } flow_result_t;

  typedef struct {
    op_e         op;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [15:0] length;
    logic [31:0] timestamp;
  } packet_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  class flow_scoreboard;
    logic        valid_q [BUCKETS*WAYS];
    entry_t      table_q [BUCKETS*WAYS];
    logic [31:0] next_id;
    flow_result_t pending[$];
    int          results_seen;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      next_id = 32'd1;
      results_seen = 0;
    endfunction

    function automatic int bucket_index(packet_t p);
      logic [31:0] lo_a, hi_a, h;
      logic [15:0] lo_p, hi_p;
      lo_a = (p.src_ip < p.dst_ip) ? p.src_ip : p.dst_ip;
      hi_a = (p.src_ip < p.dst_ip) ? p.dst_ip : p.src_ip;
      lo_p = (p.sport < p.dport) ? p.sport : p.dport;
      hi_p = (p.sport < p.dport) ? p.dport : p.sport;
      h = FNV_BASIS;
      h = (h ^ lo_a) * FNV_PRIME;
      h = (h ^ hi_a) * FNV_PRIME;
      h = (h ^ {16'd0, lo_p}) * FNV_PRIME;
      h = (h ^ {16'd0, hi_p}) * FNV_PRIME;
      h = (h ^ {24'd0, p.protocol}) * FNV_PRIME;
      return int'(h % BUCKETS);
    endfunction

    function automatic flow_result_t from_entry(status_e st, int e, logic fwd);
      flow_result_t r;
      r.status = st;
      r.conv_id = table_q[e].ident;
      r.dir_fwd = fwd;
      r.packets_fwd = table_q[e].pkts_ab;
      r.packets_rev = table_q[e].pkts_ba;
      r.byte_cnt_fwd = table_q[e].bytes_ab;
      r.byte_cnt_rev = table_q[e].bytes_ba;
      r.first_seen = table_q[e].start;
      return r;
    endfunction

    function automatic flow_result_t empty_result(status_e st);
      flow_result_t r = '{default: '0};
      r.status = st;
      return r;
    endfunction

    function automatic void note_packet(packet_t p);
      int base, hit, free_e, e;
      logic fwd;
      entry_t en;
      hit = -1;
      free_e = -1;
      if (p.op == OP_TRACK && p.protocol != PROTO_TCP && p.protocol != PROTO_UDP) begin
        pending.push_back(empty_result(ST_IGNORED));
        return;
      end
      base = bucket_index(p) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
        e = base + w;
        en = table_q[e];
        if (valid_q[e]) begin
          if (hit < 0 && en.proto == p.protocol &&
              ((en.addr_a == p.src_ip && en.addr_b == p.dst_ip &&
                en.port_a == p.sport && en.port_b == p.dport) ||
               (en.addr_a == p.dst_ip && en.addr_b == p.src_ip &&
                en.port_a == p.dport && en.port_b == p.sport)))
            hit = e;
        end else if (free_e < 0) begin
          free_e = e;
        end
      end
      if (p.op == OP_LOOKUP) begin
        if (hit < 0) pending.push_back(empty_result(ST_MISS));
        else begin
          fwd = table_q[hit].addr_a == p.src_ip && table_q[hit].port_a == p.sport;
          pending.push_back(from_entry(ST_HIT, hit, fwd));
        end
        return;
      end
      if (hit < 0) begin
        if (free_e < 0) begin
          pending.push_back(empty_result(ST_FULL));
          return;
        end
        e = free_e;
        valid_q[e] = 1'b1;
        table_q[e] = '{addr_a: p.src_ip, addr_b: p.dst_ip, port_a: p.sport,
                       port_b: p.dport, proto: p.protocol, ident: next_id,
                       start: p.timestamp, default: '0};
        next_id++;
      end else begin
        e = hit;
      end
      fwd = table_q[e].addr_a == p.src_ip && table_q[e].port_a == p.sport;
      if (fwd) begin
        table_q[e].pkts_ab++;
        table_q[e].bytes_ab += {48'd0, p.length};
      end else begin
        table_q[e].pkts_ba++;
        table_q[e].bytes_ba += {48'd0, p.length};
      end
      pending.push_back(from_entry(hit < 0 ? ST_CREATED : ST_UPDATED, e, fwd));
    endfunction

    task automatic check_result(flow_result_t got);
      flow_result_t w;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report_mismatch("status", got.status, w.status);
      if (got.conv_id !== w.conv_id) report_mismatch("conv_id", got.conv_id, w.conv_id);
      if (got.dir_fwd !== w.dir_fwd)
        report_mismatch("dir_fwd", got.dir_fwd, w.dir_fwd);
      if (got.packets_fwd !== w.packets_fwd)
        report_mismatch("packets_fwd", got.packets_fwd, w.packets_fwd);
      if (got.packets_rev !== w.packets_rev)
        report_mismatch("packets_rev", got.packets_rev, w.packets_rev);
      if (got.byte_cnt_fwd !== w.byte_cnt_fwd)
        report_mismatch("byte_cnt_fwd", got.byte_cnt_fwd, w.byte_cnt_fwd);
      if (got.byte_cnt_rev !== w.byte_cnt_rev)
        report_mismatch("byte_cnt_rev", got.byte_cnt_rev, w.byte_cnt_rev);
      if (got.first_seen !== w.first_seen)
        report_mismatch("first_seen", got.first_seen, w.first_seen);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic [31:0] src_ip_i = '0, dst_ip_i = '0, timestamp_i = '0;
  logic [15:0] sport_i = '0, dport_i = '0, length_i = '0;
  logic [7:0]  protocol_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] conv_id_o, packets_fwd_o, packets_rev_o, first_seen_o;
  logic        dir_fwd_o;
  logic [63:0] byte_cnt_fwd_o, byte_cnt_rev_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bidirectional_flow_table uut (.*);

  flow_scoreboard flows = new();
  bit long_hold = 1'b0;
  int idle_cycles = 0;
  int packets_sent = 0;
  packet_t flow_pool[$];

  // Transfers on either side are sampled at the edge, before new drives land.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      flows.note_packet('{op_e'(operation_i), src_ip_i, dst_ip_i, sport_i, dport_i,
                          protocol_i, length_i, timestamp_i});
      packets_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      flows.check_result('{status_o, conv_id_o, dir_fwd_o, packets_fwd_o, packets_rev_o,
                           byte_cnt_fwd_o, byte_cnt_rev_o, first_seen_o});
  end

  // Receiver: a repeating stall pattern, with a long hold-off on request.
  always @(posedge clk_i) begin
    int phase;
    phase = ($time / 2) % 37;
    if (long_hold) out_ready_i <= 1'b0;
    else if (phase < 12) out_ready_i <= 1'b1;
    else out_ready_i <= (phase % 3) != 0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb_bidirectional_flow_table failed");
      $finish;
    end
  end

  task automatic send_packet(packet_t p);
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= p.op;
    src_ip_i <= p.src_ip;
    dst_ip_i <= p.dst_ip;
    sport_i <= p.sport;
    dport_i <= p.dport;
    protocol_i <= p.protocol;
    length_i <= p.length;
    timestamp_i <= p.timestamp;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
  endtask

  function automatic packet_t random_packet();
    packet_t p;
    p.op = op_e'($urandom_range(0, 1));
    p.src_ip = $urandom();
    p.dst_ip = $urandom();
    p.sport = 16'($urandom());
    p.dport = 16'($urandom());
    p.protocol = 8'($urandom());
    p.length = 16'($urandom());
    p.timestamp = $urandom();
    return p;
  endfunction

  // Mostly reuses known conversations in either direction, so counters grow.
  function automatic packet_t flow_packet();
    packet_t p, q;
    int pick;
    pick = $urandom_range(0, 99);
    p = random_packet();
    p.op = ($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_TRACK;
    if (pick < 10) return random_packet();
    if (pick < 35 || flow_pool.size() == 0) begin
      p.protocol = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      if (flow_pool.size() < 64) flow_pool.push_back(p);
      return p;
    end
    q = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
    p.protocol = q.protocol;
    if ($urandom_range(0, 1)) begin
      p.src_ip = q.src_ip; p.dst_ip = q.dst_ip;
      p.sport = q.sport; p.dport = q.dport;
    end else begin
      p.src_ip = q.dst_ip; p.dst_ip = q.src_ip;
      p.sport = q.dport; p.dport = q.sport;
    end
    return p;
  endfunction

  task automatic wait_drained();
    while (flows.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    packet_t p;
    int burst, filled;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, both operations, untracked protocol, both directions.
    send_packet('{OP_LOOKUP, '1, '0, '1, '0, PROTO_TCP, '1, '1});
    send_packet('{OP_TRACK, '1, '0, '1, '0, PROTO_TCP, '1, '1});
    send_packet('{OP_TRACK, '0, '1, '0, '1, PROTO_TCP, '1, '0});
    send_packet('{OP_TRACK, '1, '0, '1, '0, PROTO_TCP, 16'd5, '0});
    send_packet('{OP_LOOKUP, '0, '1, '0, '1, PROTO_TCP, '0, '0});
    send_packet('{OP_TRACK, '0, '0, '0, '0, 8'd0, '1, '1});
    send_packet('{OP_TRACK, '0, '0, '0, '0, 8'hFF, '1, '1});
    send_packet('{OP_LOOKUP, '0, '0, '0, '0, 8'hFF, '0, '0});
    send_packet('{OP_TRACK, 32'h0A000001, 32'h0A000001, 16'd80, 16'd80, PROTO_UDP, 16'd64, 32'd7});
    send_packet('{OP_TRACK, 32'h0A000001, 32'h0A000001, 16'd80, 16'd80, PROTO_UDP, 16'd64, 32'd8});
    send_packet('{OP_LOOKUP, 32'h0A000001, 32'h0A000001, 16'd80, 16'd80, PROTO_UDP, 16'd0, 32'd0});
    send_packet('{OP_LOOKUP, 32'h0A000001, 32'h0A000001, 16'd80, 16'd80, PROTO_TCP, 16'd0, 32'd0});
    // Fill one bucket past its ways: same addresses and port 443, six source ports, so full shows.
    filled = 0;
    for (int sp = 0; sp < 65536 && filled < 6; sp++) begin
      p = '{OP_TRACK, 32'h01020304, 32'h05060708, 16'(sp), 16'd443, PROTO_TCP, 16'd1, 32'd1};
      if (flows.bucket_index(p) == 5) begin
        send_packet(p);
        filled++;
      end
    end
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      repeat (6) send_packet(flow_packet());
    join

    while (packets_sent < NUM_RANDOM + 30) begin
      burst = $urandom_range(1, 20);
      repeat (burst) send_packet(flow_packet());
      if ($urandom_range(0, 9) == 0) wait_drained();
      else repeat ($urandom_range(0, 30)) @(posedge clk_i);
    end
    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d packets and %0d results: creation, updates both ways, lookups,",
             packets_sent, flows.results_seen);
    $display("ignored protocols and a full bucket, under random stalls on both sides.");
    if (error_count == 0) $display("tb_bidirectional_flow_table passed");
    else $display("tb_bidirectional_flow_table failed");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/bft_pkg.sv
hdl/bft_hash.sv
hdl/bft_core.sv
hdl/bidirectional_flow_table.sv
hdl/bft_checker.sv
bench/tb_bidirectional_flow_table.sv
